### rtl/core/act_pkg.sv
package act_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 64;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned CARD_ID_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ENTRY_COUNT_W = 7;

  // one table entry in memory: authorized flag above the card id
  localparam int unsigned ENTRY_W = CARD_ID_W + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_DELETE   = 2'd1,
    OP_VERIFY   = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 3'd0,
    STAT_UNKNOWN   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DUPLICATE = 3'd3,
    STAT_DENIED    = 3'd4
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SCAN_RD   = 6'b000010,
    S_SCAN_CMP  = 6'b000100,
    S_SHIFT_RD  = 6'b001000,
    S_SHIFT_WR  = 6'b010000,
    S_DONE      = 6'b100000
  } seq_state_e;

  typedef struct packed {
    status_e                    status;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } act_res_t;

endpackage

### rtl/core/act_req_if.sv
interface act_req_if
  import act_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [CARD_ID_W-1:0] card_id;

  modport source (output valid, output opcode, output card_id, input ready);
  modport sink   (input valid, input opcode, input card_id, output ready);
endinterface

### rtl/core/act_rsp_if.sv
interface act_rsp_if
  import act_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

### rtl/core/act_ram.sv
module act_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/act_seq.sv
module act_seq
  import act_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic [OPCODE_W-1:0]            opcode_i,
  input  logic [CARD_ID_W-1:0]           card_id_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output act_res_t                       res_o,
  output logic                           ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr_o,
  output logic [ENTRY_W-1:0]             ram_wdata_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  input  logic [ENTRY_W-1:0]             ram_rdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  seq_state_e            state_q, state_d;
  opcode_e               op_q, op_d;
  logic [CARD_ID_W-1:0]  id_q, id_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  status_e               status_q, status_d;
  logic [CW-1:0]         idx_nx;
  logic [CW+ENTRY_COUNT_W-1:0] cnt_ext;
  logic                  hit;

  assign idx_nx  = idx_q + CW'(1);
  assign cnt_ext = {{ENTRY_COUNT_W{1'b0}}, cnt_q};
  assign hit     = (ram_rdata_i[CARD_ID_W-1:0] == id_q);

  assign req_ready_o       = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = status_q;
  assign res_o.entry_count = cnt_ext[ENTRY_COUNT_W-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    status_d    = status_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q[AW-1:0];
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d  = opcode_e'(opcode_i);
          id_d  = card_id_i;
          idx_d = '0;
          case (opcode_e'(opcode_i))
            OP_REGISTER: begin
              if (cnt_q >= CW'(TABLE_DEPTH)) begin
                status_d = STAT_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            OP_DELETE, OP_VERIFY: begin
              state_d = S_SCAN_RD;
            end
            default: begin
              status_d = STAT_UNKNOWN;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx_q < cnt_q) begin
          state_d = S_SCAN_CMP;
        end else begin
          // searched every held entry without a match
          state_d = S_DONE;
          if (op_q == OP_REGISTER) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = cnt_q[AW-1:0];
            ram_wdata_o = {1'b1, id_q};
            cnt_d       = cnt_q + CW'(1);
            status_d    = STAT_DONE;
          end else begin
            status_d = STAT_UNKNOWN;
          end
        end
      end
      S_SCAN_CMP: begin
        if (hit) begin
          case (op_q)
            OP_REGISTER: begin
              status_d = STAT_DUPLICATE;
              state_d  = S_DONE;
            end
            OP_VERIFY: begin
              status_d = ram_rdata_i[CARD_ID_W] ? STAT_DONE : STAT_DENIED;
              state_d  = S_DONE;
            end
            default: begin
              state_d = S_SHIFT_RD;
            end
          endcase
        end else begin
          idx_d   = idx_nx;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        ram_raddr_o = idx_nx[AW-1:0];
        if (idx_nx < cnt_q) begin
          state_d = S_SHIFT_WR;
        end else begin
          cnt_d    = cnt_q - CW'(1);
          status_d = STAT_DONE;
          state_d  = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        // entry idx+1 moves down to idx
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q[AW-1:0];
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_nx;
        state_d     = S_SHIFT_RD;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      op_q     <= OP_VERIFY;
      status_q <= STAT_UNKNOWN;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      op_q     <= op_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CW'(1) || cnt_q == $past(cnt_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == S_SCAN_RD || state_q == S_SHIFT_WR))
    else $error("table write outside append or shift");

  a_cmp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CMP || state_q == S_SHIFT_WR) |-> idx_q < cnt_q)
    else $error("compare or shift on an entry not held");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> state_q != S_IDLE)
    else $error("accepted request left no work");
`endif

endmodule

### rtl/core/access_card_table.sv
// access card table: holds up to TABLE_DEPTH 32-bit card ids packed from entry 0
// upward in a single-port-write, registered-read memory, each with an authorized
// flag. requests carry an opcode (register, delete, verify) and a card id; every
// request returns exactly one response with a status and the entry count after
// the operation. register appends the id (status full when the table is at
// capacity, checked first, duplicate when already held); delete removes the first
// match and moves every later entry down one place (not found otherwise); verify
// returns granted, denied or unknown. requests are handled one at a time by a
// sequencer that walks the memory: a search reads each held entry, then compares
// on the registered read data, and a delete reads and writes each entry moved;
// a register on a full table or a bad opcode answers without a search. the
// response sits in an output register, so the next request is taken while an
// earlier response still waits. the table is empty after reset with no clearing
// pass; entry_count shows the low 7 bits of the count.
module access_card_table
  import act_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  act_req_if.sink   req_i,
  act_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // sequencer to memory
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // sequencer to output register
  logic     res_valid;
  logic     res_ready;
  act_res_t res;

  // output register
  logic     out_valid_q;
  act_res_t out_q;

  act_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .opcode_i    (req_i.opcode),
    .card_id_i   (req_i.card_id),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // id and flag share one word; shift reads entry j+1, then writes it to entry j; read
  // data from an entry written in the same cycle is never used, so no forwarding path is needed
  act_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the slot frees up in the same cycle the downstream takes the response
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // response payload, loaded whenever the slot takes a new response
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.entry_count = out_q.entry_count;

endmodule

### tb/sv/access_card_table_test.sv
`timescale 1ns / 100ps

module access_card_table_test;
  import act_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEFAULT;
  // opcode value with no operation behind it, the block must answer unknown
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  // longest correct quiet stretch is an output hold plus one full scan
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_PRINTS = 40;

  typedef enum int {
    PH_FILL,
    PH_CHURN,
    PH_DRAIN
  } phase_e;

  // expected-response tracker with its own copy of the card table
  class card_table_scoreboard;
    logic [CARD_ID_W-1:0] held_ids[$];
    bit                   allow_bits[$];
    act_res_t             pending_replies[$];
    int                   fault_count;

    function new();
      fault_count = 0;
    endfunction

    task report_mismatch(input string msg);
      fault_count++;
      if (fault_count <= MAX_PRINTS) begin
        $display("error at %0t: %s", $time, msg);
      end
    endtask

    // apply one request to the table copy and return the response it must give
    function act_res_t apply_card_op(input logic [OPCODE_W-1:0] op,
                                     input logic [CARD_ID_W-1:0] id);
      act_res_t res;
      int hit;
      hit = -1;
      for (int i = 0; i < held_ids.size(); i++) begin
        if (held_ids[i] == id) begin
          hit = i;
          break;
        end
      end
      res.status = STAT_UNKNOWN;
      case (op)
        OP_REGISTER: begin
          // capacity is checked ahead of the duplicate search
          if (held_ids.size() >= DEPTH) begin
            res.status = STAT_FULL;
          end else if (hit >= 0) begin
            res.status = STAT_DUPLICATE;
          end else begin
            held_ids.push_back(id);
            allow_bits.push_back(1'b1);
            res.status = STAT_DONE;
          end
        end
        OP_DELETE: begin
          // queue delete closes the gap just like the block's shift
          if (hit >= 0) begin
            held_ids.delete(hit);
            allow_bits.delete(hit);
            res.status = STAT_DONE;
          end
        end
        OP_VERIFY: begin
          if (hit >= 0) begin
            res.status = allow_bits[hit] ? STAT_DONE : STAT_DENIED;
          end
        end
        default: begin
        end
      endcase
      res.entry_count = ENTRY_COUNT_W'(held_ids.size());
      return res;
    endfunction

    function void note_request(input logic [OPCODE_W-1:0] op,
                               input logic [CARD_ID_W-1:0] id);
      pending_replies.push_back(apply_card_op(op, id));
    endfunction

    task check_result(input logic [STATUS_W-1:0] status,
                      input logic [ENTRY_COUNT_W-1:0] count);
      act_res_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: status %0d count %0d",
                                  status, count));
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status) begin
        report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
      end
      if (count !== want.entry_count) begin
        report_mismatch($sformatf("entry_count %0d, wanted %0d", count, want.entry_count));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  act_req_if req_if ();
  act_rsp_if rsp_if ();

  access_card_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  card_table_scoreboard sb = new();

  int     idle_cycles = 0;
  int     items_sent = 0;
  bit     burst_mode = 1'b0;
  // sender asks for a long output hold, receiver flags while it is holding
  bit     hold_request = 1'b0;
  bit     hold_active = 1'b0;
  phase_e phase;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // response side: check every accepted response and watch for progress
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.status, rsp_if.entry_count);
    end
    if (rst_ni && ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // nothing moved on either side for too long
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // card id: a held one with the given odds, else near misses, edge values or random
  function automatic logic [CARD_ID_W-1:0] pick_card_id(input int held_pct);
    int n;
    int r;
    logic [CARD_ID_W-1:0] id;
    n = sb.held_ids.size();
    if (n > 0 && $urandom_range(0, 99) < held_pct) begin
      return sb.held_ids[$urandom_range(0, n - 1)];
    end
    r = $urandom_range(0, 9);
    if (n > 0 && r == 0) begin
      // one bit away from a held id, exercises the full-width compare
      id = sb.held_ids[$urandom_range(0, n - 1)];
      return id ^ (CARD_ID_W'(1) << $urandom_range(0, CARD_ID_W - 1));
    end
    if (r == 1) return CARD_ID_W'($urandom_range(0, 15));
    if (r == 2) return ~CARD_ID_W'($urandom_range(0, 15));
    return $urandom();
  endfunction

  // offer one request, hold it until taken, note it, then idle for a gap
  task automatic issue_card_op(input logic [OPCODE_W-1:0] op,
                               input logic [CARD_ID_W-1:0] id);
    int gap;
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.card_id <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(op, id);
    items_sent++;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every outstanding response
  task automatic settle_replies();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // receiver goes quiet for a long stretch while requests keep coming back to back,
  // so the output register fills and the block has to stall its input
  task automatic stall_output_burst();
    bit saved;
    saved = burst_mode;
    // withdraw the last request while waiting for the hold to start
    req_if.valid <= 1'b0;
    hold_request = 1'b1;
    @(posedge clk_i);
    while (!hold_active) @(posedge clk_i);
    burst_mode = 1'b1;
    repeat (8) begin
      case ($urandom_range(0, 2))
        0: issue_card_op(OP_REGISTER, pick_card_id(20));
        1: issue_card_op(OP_DELETE, pick_card_id(60));
        default: issue_card_op(OP_VERIFY, pick_card_id(60));
      endcase
    end
    burst_mode = saved;
  endtask

  // response ready: short on/off bursts, long fully-ready stretches, one-off holds
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(100, 300)) @(posedge clk_i);
      end else begin
        int off_len;
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        off_len = pick_gap();
        if (off_len > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (off_len) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.opcode  <= OP_REGISTER;
    req_if.card_id <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extreme ids, duplicates, shifts, unused opcode
    issue_card_op(OP_VERIFY, 32'h0000_0000);
    issue_card_op(OP_DELETE, 32'h0000_0000);
    issue_card_op(OP_UNUSED, 32'h0000_0000);
    issue_card_op(OP_REGISTER, 32'h0000_0000);
    issue_card_op(OP_REGISTER, 32'hFFFF_FFFF);
    issue_card_op(OP_REGISTER, 32'hFFFF_FFFF);
    issue_card_op(OP_REGISTER, 32'h0000_0000);
    issue_card_op(OP_VERIFY, 32'hFFFF_FFFF);
    issue_card_op(OP_VERIFY, 32'h0000_0000);
    issue_card_op(OP_VERIFY, 32'hFFFF_FFFE);
    issue_card_op(OP_REGISTER, 32'hA5A5_A5A5);
    issue_card_op(OP_REGISTER, 32'h5A5A_5A5A);
    // delete from the middle, later entries move down
    issue_card_op(OP_DELETE, 32'hFFFF_FFFF);
    issue_card_op(OP_VERIFY, 32'h5A5A_5A5A);
    issue_card_op(OP_DELETE, 32'h5A5A_5A5A);
    issue_card_op(OP_DELETE, 32'h0000_0000);
    issue_card_op(OP_DELETE, 32'h0000_0000);
    issue_card_op(OP_UNUSED, 32'hA5A5_A5A5);
    issue_card_op(OP_VERIFY, 32'h8000_0000);
    issue_card_op(OP_DELETE, 32'hA5A5_A5A5);
    issue_card_op(OP_VERIFY, 32'hA5A5_A5A5);
    settle_replies();

    stall_output_burst();
    settle_replies();

    // random: fill to capacity, churn, drain to empty, in random order
    items_sent = 0;
    phase = PH_FILL;
    while (items_sent < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      case (phase)
        PH_FILL: begin
          while (sb.held_ids.size() < DEPTH) begin
            if ($urandom_range(0, 9) == 0) begin
              issue_card_op(OP_VERIFY, pick_card_id(50));
            end else begin
              issue_card_op(OP_REGISTER, pick_card_id(5));
            end
          end
          // full table: held and new ids both answer full
          repeat ($urandom_range(2, 5)) issue_card_op(OP_REGISTER, pick_card_id(50));
        end
        PH_DRAIN: begin
          while (sb.held_ids.size() > 0) begin
            case ($urandom_range(0, 19))
              0, 1, 2: issue_card_op(OP_DELETE, pick_card_id(0));
              3, 4, 5: issue_card_op(OP_VERIFY, pick_card_id(50));
              default: issue_card_op(OP_DELETE, pick_card_id(100));
            endcase
          end
          issue_card_op(OP_DELETE, pick_card_id(0));
          issue_card_op(OP_VERIFY, pick_card_id(0));
        end
        default: begin
          if ($urandom_range(0, 7) == 0) stall_output_burst();
          repeat ($urandom_range(20, 60)) begin
            case ($urandom_range(0, 19))
              0: issue_card_op(OP_UNUSED, pick_card_id(50));
              1, 2, 3, 4, 5, 6, 7: issue_card_op(OP_REGISTER, pick_card_id(30));
              8, 9, 10, 11, 12, 13: issue_card_op(OP_DELETE, pick_card_id(60));
              default: issue_card_op(OP_VERIFY, pick_card_id(60));
            endcase
          end
        end
      endcase
      // sender pause until the block has answered everything
      if ($urandom_range(0, 2) == 0) settle_replies();
      if (sb.held_ids.size() >= DEPTH) begin
        phase = ($urandom_range(0, 1) == 0) ? PH_DRAIN : PH_CHURN;
      end else if (sb.held_ids.size() == 0) begin
        phase = ($urandom_range(0, 1) == 0) ? PH_FILL : PH_CHURN;
      end else begin
        case ($urandom_range(0, 2))
          0: phase = PH_FILL;
          1: phase = PH_DRAIN;
          default: phase = PH_CHURN;
        endcase
      end
    end

    settle_replies();
    // let any stray response show up before calling it
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
